[src/tw_odo_pkg.sv]
// tw_odo_pkg: shared types, codes and constants of the arc odometry block
// used by tw_odo_mdu and two_wheel_arc_odometry; depends on nothing
`default_nettype none

package tw_odo_pkg;

    // default fixed-point layout
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 32;

    // shared multiply / divide unit
    localparam int WIDE_W    = 64;
    localparam int MUL_DIGIT = 4;
    localparam int MUL_STEPS = WIDE_W / MUL_DIGIT;
    localparam int DIV_STEPS = WIDE_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic        [WIDE_W-1:0] t_uwide;

    // operation codes of the unit
    typedef logic t_mdu_op;
    localparam t_mdu_op OP_MUL = 1'b0;
    localparam t_mdu_op OP_DIV = 1'b1;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
        t_wide   a;
        t_wide   b;
    } t_mdu_req;

    typedef struct packed {
        logic  busy;
        logic  done;
        t_wide prod;
        t_wide quo;
        t_wide rem;
    } t_mdu_rsp;

    // request kinds
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_SET    = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 25;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ST_TRAVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FW_TRAVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ST_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FW_OFFSET  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN  = 3'd5;
    localparam logic [16:0]          GYRO_GAIN_RST  = 17'd65536;

    // sine series constants, Q30, and the radian-to-degree factor, Q32
    localparam t_wide ONE_Q30     = 64'sd1073741824;
    localparam t_wide HALF_PI_Q30 = 64'sd1686629713;
    localparam t_wide RAD2DEG_Q32 = 64'sd246083499208;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] strafe_count;
        logic signed [31:0] forward_count;
        logic        [24:0] gyro_angle;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic        [24:0] set_heading;
        logic               write_x;
        logic               write_y;
        logic               write_heading;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic        [24:0] pose_heading;
    } t_out_word;

endpackage

`default_nettype wire

[src/two_wheel_arc_odometry.sv]
// two_wheel_arc_odometry: dead-reckoning pose tracker with sequencer
// depends on tw_odo_pkg and tw_odo_mdu
//
// Usage: one input word per item on i_in_word (valid/stall), one result word
// per item on o_out_word giving the pose after the item. Configuration is
// written through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Items are processed one at a time; o_in_stall is high while an item is at
// work. All arithmetic goes through one shared unit: a multiply takes 16
// steps (four bits a cycle), a divide 64 (one quotient bit a cycle), each
// plus a hand-off to and from the sequencer.
// An update with a turn uses 22 divides and 36 multiplies of the unit.
// The result sits in an output register; while the receiver stalls it holds,
// and the next item may be accepted, finishing only when the register frees.
// Reset (synchronous, active low) clears the pose, the stored samples and
// the configuration (gain to 1.0, disabled).
`default_nettype none

module two_wheel_arc_odometry
    import tw_odo_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_word              i_in_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_word                  o_out_word,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int    HW        = 9 + FRAC_BITS;
    localparam t_wide TURN      = t_wide'(360) <<< FRAC_BITS;
    localparam t_wide HALF_TURN = t_wide'(180) <<< FRAC_BITS;
    localparam t_wide TWO_TURN  = TURN <<< 1;
    localparam t_wide KQ        = (RAD2DEG_Q32 + (t_wide'(1) <<< (31 - FRAC_BITS)))
                                  >>> (32 - FRAC_BITS);
    localparam t_wide SIN_RND   = t_wide'(1) <<< (29 - FRAC_BITS);
    localparam t_wide UNIT_ONE  = t_wide'(1) <<< FRAC_BITS;
    localparam t_wide S32_MAX   = 64'sd2147483647;
    localparam t_wide S32_MIN   = -64'sd2147483648;

    // sequencer states
    localparam int SW = 6;
    localparam logic [SW-1:0] S_IDLE = 6'd0;
    localparam logic [SW-1:0] S_WAIT = 6'd1;
    localparam logic [SW-1:0] S_SP2  = 6'd2;
    localparam logic [SW-1:0] S_U0   = 6'd3;
    localparam logic [SW-1:0] S_U1   = 6'd4;
    localparam logic [SW-1:0] S_U2   = 6'd5;
    localparam logic [SW-1:0] S_U3   = 6'd6;
    localparam logic [SW-1:0] S_U4   = 6'd7;
    localparam logic [SW-1:0] S_U5   = 6'd8;
    localparam logic [SW-1:0] S_U6   = 6'd9;
    localparam logic [SW-1:0] S_U7   = 6'd10;
    localparam logic [SW-1:0] S_U8   = 6'd11;
    localparam logic [SW-1:0] S_U9   = 6'd12;
    localparam logic [SW-1:0] S_U10  = 6'd13;
    localparam logic [SW-1:0] S_U11  = 6'd14;
    localparam logic [SW-1:0] S_U12  = 6'd15;
    localparam logic [SW-1:0] S_U13  = 6'd16;
    localparam logic [SW-1:0] S_HEAD = 6'd17;
    localparam logic [SW-1:0] S_U15  = 6'd18;
    localparam logic [SW-1:0] S_U16  = 6'd19;
    localparam logic [SW-1:0] S_U17  = 6'd20;
    localparam logic [SW-1:0] S_U18  = 6'd21;
    localparam logic [SW-1:0] S_U19  = 6'd22;
    localparam logic [SW-1:0] S_U20  = 6'd23;
    localparam logic [SW-1:0] S_SIN0 = 6'd24;
    localparam logic [SW-1:0] S_SIN1 = 6'd25;
    localparam logic [SW-1:0] S_SIN2 = 6'd26;
    localparam logic [SW-1:0] S_SIN3 = 6'd27;
    localparam logic [SW-1:0] S_SIN4 = 6'd28;
    localparam logic [SW-1:0] S_SIN5 = 6'd29;
    localparam logic [SW-1:0] S_SIN6 = 6'd30;
    localparam logic [SW-1:0] S_DONE = 6'd31;

    // round to nearest, ties away from zero, dropping FRAC_BITS bits
    function automatic t_wide rsh_round(input t_wide v);
        t_wide m;
        m = (v < 0) ? -v : v;
        m = (m + (t_wide'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return (v < 0) ? -m : m;
    endfunction

    function automatic t_wide sat32(input t_wide v);
        if (v > S32_MAX) begin
            return S32_MAX;
        end else if (v < S32_MIN) begin
            return S32_MIN;
        end
        return v;
    endfunction

    function automatic t_wide abs_w(input t_wide v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_wide ext_cnt(input logic [31:0] v);
        logic signed [COUNT_BITS-1:0] c;
        c = v[COUNT_BITS-1:0];
        return t_wide'(c);
    endfunction

    // divisors of the sine series
    function automatic t_wide horner_div(input logic [2:0] i);
        unique case (i)
            3'd0:    return t_wide'(110);
            3'd1:    return t_wide'(72);
            3'd2:    return t_wide'(42);
            3'd3:    return t_wide'(20);
            default: return t_wide'(6);
        endcase
    endfunction

    // configuration registers
    logic                 r_en;
    logic        [23:0]   r_st_trav;
    logic        [23:0]   r_fw_trav;
    logic signed [24:0]   r_st_off;
    logic signed [24:0]   r_fw_off;
    logic        [16:0]   r_gain;

    // pose and stored samples
    logic signed [COUNT_BITS-1:0] r_last_s, n_last_s;
    logic signed [COUNT_BITS-1:0] r_last_f, n_last_f;
    logic        [HW-1:0]         r_last_g, n_last_g;
    logic        [HW-1:0]         r_acc_h,  n_acc_h;
    logic signed [31:0]           r_acc_x,  n_acc_x;
    logic signed [31:0]           r_acc_y,  n_acc_y;

    // sequencer and working registers
    logic [SW-1:0] r_state, n_state;
    logic [SW-1:0] r_ret,   n_ret;
    logic [SW-1:0] r_sret,  n_sret;
    t_in_word      r_in,    n_in;
    t_wide r_dse, n_dse, r_dfe, n_dfe, r_dh, n_dh, r_c, n_c, r_s, n_s;
    t_wide r_dx, n_dx, r_dy, n_dy, r_nh, n_nh, r_sn, n_sn, r_cs, n_cs;
    t_wide r_tmp, n_tmp, r_sa, n_sa, r_sz, n_sz, r_sz2, n_sz2, r_sres, n_sres;
    logic          r_neg, n_neg;
    logic [1:0]    r_sq,  n_sq;
    logic [2:0]    r_si,  n_si;
    logic          r_out_valid, n_out_valid;
    t_out_word     r_out, n_out;

    t_mdu_req req;
    t_mdu_rsp rsp;

    tw_odo_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // sequencer
    always_comb begin
        t_wide      v_a;
        t_wide      v_r;
        t_wide      v_s;
        logic [1:0] v_q;

        n_state = r_state;  n_ret = r_ret;  n_sret = r_sret;  n_in = r_in;
        n_last_s = r_last_s;  n_last_f = r_last_f;  n_last_g = r_last_g;
        n_acc_h = r_acc_h;  n_acc_x = r_acc_x;  n_acc_y = r_acc_y;
        n_dse = r_dse;  n_dfe = r_dfe;  n_dh = r_dh;  n_c = r_c;  n_s = r_s;
        n_dx = r_dx;  n_dy = r_dy;  n_nh = r_nh;  n_sn = r_sn;  n_cs = r_cs;
        n_tmp = r_tmp;  n_sa = r_sa;  n_sz = r_sz;  n_sz2 = r_sz2;
        n_sres = r_sres;  n_neg = r_neg;  n_sq = r_sq;  n_si = r_si;
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        req = '0;
        v_a = '0;
        v_r = '0;
        v_s = '0;
        v_q = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in = i_in_word;
                    if (!r_en) begin
                        n_state = S_DONE;
                    end else if (i_in_word.req_type == REQ_SET) begin
                        n_last_s = '0;
                        n_last_f = '0;
                        if (i_in_word.write_x) begin
                            n_acc_x = i_in_word.new_x;
                        end
                        if (i_in_word.write_y) begin
                            n_acc_y = i_in_word.new_y;
                        end
                        if (i_in_word.write_heading) begin
                            req = '{1'b1, OP_DIV, t_wide'(i_in_word.set_heading), TURN};
                            n_ret   = S_SP2;
                            n_state = S_WAIT;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        n_state = S_U0;
                    end
                end
            end
            S_WAIT: begin
                if (rsp.done) begin
                    n_state = r_ret;
                end
            end
            S_SP2: begin
                n_acc_h  = rsp.rem[HW-1:0];
                n_last_g = rsp.rem[HW-1:0];
                n_state  = S_DONE;
            end
            // wheel moves
            S_U0: begin
                req = '{1'b1, OP_MUL, ext_cnt(r_in.strafe_count) - t_wide'(r_last_s),
                        t_wide'(r_st_trav)};
                n_ret = S_U1;  n_state = S_WAIT;
            end
            S_U1: begin
                n_neg = rsp.prod < 0;
                req = '{1'b1, OP_DIV, abs_w(rsp.prod) + t_wide'(180), t_wide'(360)};
                n_ret = S_U2;  n_state = S_WAIT;
            end
            S_U2: begin
                n_dse = sat32(r_neg ? -rsp.quo : rsp.quo);
                req = '{1'b1, OP_MUL, ext_cnt(r_in.forward_count) - t_wide'(r_last_f),
                        t_wide'(r_fw_trav)};
                n_ret = S_U3;  n_state = S_WAIT;
            end
            S_U3: begin
                n_neg = rsp.prod < 0;
                req = '{1'b1, OP_DIV, abs_w(rsp.prod) + t_wide'(180), t_wide'(360)};
                n_ret = S_U4;  n_state = S_WAIT;
            end
            S_U4: begin
                n_dfe    = sat32(r_neg ? -rsp.quo : rsp.quo);
                n_last_s = r_in.strafe_count[COUNT_BITS-1:0];
                n_last_f = r_in.forward_count[COUNT_BITS-1:0];
                req = '{1'b1, OP_DIV, t_wide'(r_in.gyro_angle), TURN};
                n_ret = S_U5;  n_state = S_WAIT;
            end
            // shortest imu turn times gain
            S_U5: begin
                v_a = rsp.rem;
                v_r = v_a - t_wide'(r_last_g);
                if (v_r > HALF_TURN) begin
                    v_r = v_r - TURN;
                end else if (v_r < -HALF_TURN) begin
                    v_r = v_r + TURN;
                end
                n_last_g = v_a[HW-1:0];
                req = '{1'b1, OP_MUL, v_r, t_wide'(r_gain)};
                n_ret = S_U6;  n_state = S_WAIT;
            end
            S_U6: begin
                v_s  = rsh_round(rsp.prod);
                n_dh = v_s;
                if (v_s == 0) begin
                    n_dx = r_dse;
                    n_dy = r_dfe;
                    n_state = S_HEAD;
                end else begin
                    n_sa = v_s;
                    n_sret = S_U7;
                    n_state = S_SIN0;
                end
            end
            // arc correction
            S_U7: begin
                v_s = r_sres <<< 1;
                n_c = v_s;
                req = '{1'b1, OP_MUL, v_s, KQ};
                n_ret = S_U8;  n_state = S_WAIT;
            end
            S_U8: begin
                n_neg = (rsp.prod < 0) != (r_dh < 0);
                req = '{1'b1, OP_DIV, abs_w(rsp.prod) + (abs_w(r_dh) >>> 1), abs_w(r_dh)};
                n_ret = S_U9;  n_state = S_WAIT;
            end
            S_U9: begin
                v_s = r_neg ? -rsp.quo : rsp.quo;
                n_s = v_s;
                req = '{1'b1, OP_MUL, r_dse, v_s};
                n_ret = S_U10;  n_state = S_WAIT;
            end
            S_U10: begin
                n_dx = rsh_round(rsp.prod);
                req = '{1'b1, OP_MUL, r_c, t_wide'(r_st_off)};
                n_ret = S_U11;  n_state = S_WAIT;
            end
            S_U11: begin
                n_dx = r_dx + rsh_round(rsp.prod);
                req = '{1'b1, OP_MUL, r_dfe, r_s};
                n_ret = S_U12;  n_state = S_WAIT;
            end
            S_U12: begin
                n_dy = rsh_round(rsp.prod);
                req = '{1'b1, OP_MUL, r_c, t_wide'(r_fw_off)};
                n_ret = S_U13;  n_state = S_WAIT;
            end
            S_U13: begin
                n_dy = r_dy + rsh_round(rsp.prod);
                n_state = S_HEAD;
            end
            // new heading and its sine and cosine
            S_HEAD: begin
                v_a = t_wide'(r_acc_h) + r_dh;
                if (v_a < 0) begin
                    v_a = v_a + TURN;
                end else if (v_a >= TURN) begin
                    v_a = v_a - TURN;
                end
                n_nh = v_a;
                n_sa = v_a <<< 1;
                n_sret = S_U15;
                n_state = S_SIN0;
            end
            S_U15: begin
                n_sn = r_sres;
                n_sa = (r_nh <<< 1) + HALF_TURN;
                n_sret = S_U16;
                n_state = S_SIN0;
            end
            // rotation into the field frame
            S_U16: begin
                n_cs = r_sres;
                req = '{1'b1, OP_MUL, r_dx, r_sres};
                n_ret = S_U17;  n_state = S_WAIT;
            end
            S_U17: begin
                n_tmp = rsp.prod;
                req = '{1'b1, OP_MUL, r_dy, r_sn};
                n_ret = S_U18;  n_state = S_WAIT;
            end
            S_U18: begin
                v_s = sat32(t_wide'(r_acc_x) + rsh_round(r_tmp + rsp.prod));
                n_acc_x = v_s[31:0];
                req = '{1'b1, OP_MUL, r_dy, r_cs};
                n_ret = S_U19;  n_state = S_WAIT;
            end
            S_U19: begin
                n_tmp = rsp.prod;
                req = '{1'b1, OP_MUL, r_dx, r_sn};
                n_ret = S_U20;  n_state = S_WAIT;
            end
            S_U20: begin
                v_s = sat32(t_wide'(r_acc_y) + rsh_round(r_tmp - rsp.prod));
                n_acc_y = v_s[31:0];
                n_acc_h = r_nh[HW-1:0];
                n_state = S_DONE;
            end
            // sine subroutine: fold to a quadrant, then odd series by horner
            S_SIN0: begin
                v_a = r_sa;
                if (v_a < 0) begin
                    v_a = v_a + TWO_TURN;
                end else if (v_a >= TWO_TURN) begin
                    v_a = v_a - TWO_TURN;
                end
                if (v_a >= HALF_TURN * 3) begin
                    v_q = 2'd3;  v_r = v_a - HALF_TURN * 3;
                end else if (v_a >= HALF_TURN * 2) begin
                    v_q = 2'd2;  v_r = v_a - HALF_TURN * 2;
                end else if (v_a >= HALF_TURN) begin
                    v_q = 2'd1;  v_r = v_a - HALF_TURN;
                end else begin
                    v_q = 2'd0;  v_r = v_a;
                end
                if (v_q[0]) begin
                    v_r = HALF_TURN - v_r;
                end
                n_sq = v_q;
                req = '{1'b1, OP_DIV, v_r <<< 30, HALF_TURN};
                n_ret = S_SIN1;  n_state = S_WAIT;
            end
            S_SIN1: begin
                req = '{1'b1, OP_MUL, rsp.quo, HALF_PI_Q30};
                n_ret = S_SIN2;  n_state = S_WAIT;
            end
            S_SIN2: begin
                v_s  = rsp.prod >>> 30;
                n_sz = v_s;
                req = '{1'b1, OP_MUL, v_s, v_s};
                n_ret = S_SIN3;  n_state = S_WAIT;
            end
            S_SIN3: begin
                v_s   = rsp.prod >>> 30;
                n_sz2 = v_s;
                n_si  = '0;
                req = '{1'b1, OP_MUL, v_s, ONE_Q30};
                n_ret = S_SIN4;  n_state = S_WAIT;
            end
            S_SIN4: begin
                req = '{1'b1, OP_DIV, rsp.prod >>> 30, horner_div(r_si)};
                n_ret = S_SIN5;  n_state = S_WAIT;
            end
            S_SIN5: begin
                v_s  = ONE_Q30 - rsp.quo;
                n_si = r_si + 1'b1;
                if (r_si == 3'd4) begin
                    req = '{1'b1, OP_MUL, r_sz, v_s};
                    n_ret = S_SIN6;
                end else begin
                    req = '{1'b1, OP_MUL, r_sz2, v_s};
                    n_ret = S_SIN4;
                end
                n_state = S_WAIT;
            end
            S_SIN6: begin
                v_s = rsp.prod >>> 30;
                v_s = (v_s + SIN_RND) >>> (30 - FRAC_BITS);
                if (v_s > UNIT_ONE) begin
                    v_s = UNIT_ONE;
                end
                n_sres  = r_sq[1] ? -v_s : v_s;
                n_state = r_sret;
            end
            // hand the pose to the output register
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out.pose_x = r_acc_x;
                    n_out.pose_y = r_acc_y;
                    n_out.pose_heading = 25'(r_acc_h);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control, configuration and pose registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_en        <= 1'b0;
            r_st_trav   <= '0;
            r_fw_trav   <= '0;
            r_st_off    <= '0;
            r_fw_off    <= '0;
            r_gain      <= GYRO_GAIN_RST;
            r_last_s    <= '0;
            r_last_f    <= '0;
            r_last_g    <= '0;
            r_acc_h     <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_last_s    <= n_last_s;
            r_last_f    <= n_last_f;
            r_last_g    <= n_last_g;
            r_acc_h     <= n_acc_h;
            r_acc_x     <= n_acc_x;
            r_acc_y     <= n_acc_y;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ENABLE:    r_en      <= i_cfg_data[0];
                    CFG_ST_TRAVEL: r_st_trav <= i_cfg_data[23:0];
                    CFG_FW_TRAVEL: r_fw_trav <= i_cfg_data[23:0];
                    CFG_ST_OFFSET: r_st_off  <= i_cfg_data;
                    CFG_FW_OFFSET: r_fw_off  <= i_cfg_data;
                    CFG_GYRO_GAIN: r_gain    <= i_cfg_data[16:0];
                    default:       ;
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;  r_sret <= n_sret;  r_in <= n_in;
        r_dse <= n_dse;  r_dfe <= n_dfe;  r_dh <= n_dh;  r_c <= n_c;  r_s <= n_s;
        r_dx <= n_dx;  r_dy <= n_dy;  r_nh <= n_nh;  r_sn <= n_sn;  r_cs <= n_cs;
        r_tmp <= n_tmp;  r_sa <= n_sa;  r_sz <= n_sz;  r_sz2 <= n_sz2;
        r_sres <= n_sres;  r_neg <= n_neg;  r_sq <= n_sq;  r_si <= n_si;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // checks
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word changed");

    a_head_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (t_wide'(r_acc_h) < TURN))
        else $error("heading not below a full turn");

    a_wait_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (rsp.busy || rsp.done))
        else $error("waiting on an idle unit");

endmodule

`default_nettype wire

[src/tw_odo_mdu.sv]
// tw_odo_mdu: shared digit-serial unit, signed multiply four bits a cycle
// and unsigned restoring divide one bit a cycle; depends on tw_odo_pkg
`default_nettype none

module tw_odo_mdu
    import tw_odo_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mdu_req i_req,
    output t_mdu_rsp      o_rsp
);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    t_mdu_op          r_op;
    logic             r_neg;
    t_uwide           r_ma;
    t_uwide           r_mb;
    t_uwide           r_acc;
    t_wide            r_prod;
    t_uwide           r_q;
    t_uwide           r_d;
    t_uwide           r_rem;

    t_uwide           mag_a;
    t_uwide           mag_b;
    t_uwide           pp;
    t_uwide           n_acc;
    logic [WIDE_W:0]  shifted;
    logic [WIDE_W:0]  trial;

    // operand magnitudes and one step of each operation
    always_comb begin
        mag_a   = i_req.a[WIDE_W-1] ? t_uwide'(-i_req.a) : t_uwide'(i_req.a);
        mag_b   = i_req.b[WIDE_W-1] ? t_uwide'(-i_req.b) : t_uwide'(i_req.b);
        pp      = r_ma * r_mb[MUL_DIGIT-1:0];
        n_acc   = r_acc + pp;
        shifted = {r_rem, r_q[WIDE_W-1]};
        trial   = shifted - {1'b0, r_d};
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= (i_req.op == OP_MUL) ? CNT_W'(MUL_STEPS) : CNT_W'(DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_neg <= i_req.a[WIDE_W-1] ^ i_req.b[WIDE_W-1];
            r_ma  <= mag_a;
            r_mb  <= mag_b;
            r_acc <= '0;
            r_q   <= t_uwide'(i_req.a);
            r_d   <= t_uwide'(i_req.b);
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            if (r_op == OP_MUL) begin
                r_acc  <= n_acc;
                r_ma   <= r_ma << MUL_DIGIT;
                r_mb   <= r_mb >> MUL_DIGIT;
                r_prod <= r_neg ? -t_wide'(n_acc) : t_wide'(n_acc);
            end else if (!trial[WIDE_W]) begin
                r_rem <= trial[WIDE_W-1:0];
                r_q   <= {r_q[WIDE_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[WIDE_W-1:0];
                r_q   <= {r_q[WIDE_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.busy = (r_cnt != '0);
    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_prod;
    assign o_rsp.quo  = t_wide'(r_q);
    assign o_rsp.rem  = t_wide'(r_rem);

    // checks
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> !i_req.start)
        else $error("unit started while busy");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_cnt) == CNT_W'(1)))
        else $error("done without a last step");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_op == OP_DIV && r_d != '0) |-> (r_rem < r_d))
        else $error("remainder not below divisor");

endmodule

`default_nettype wire
